// ===== hdl/sgni_pkg.sv =====
package sgni_pkg;

    localparam int NUM_DIMS  = 4;
    localparam int MAX_DIMS  = 4;
    localparam int CELL_BITS = 10;
    localparam int CRD_BITS  = CELL_BITS + 1;
    localparam int IDX_BITS  = 48;
    localparam int DIV_STEPS = 4;

    localparam logic [2:0] MODE_CC  = 3'd0;
    localparam logic [2:0] MODE_VV  = 3'd1;
    localparam logic [2:0] MODE_FC  = 3'd2;
    localparam logic [2:0] MODE_CF  = 3'd3;
    localparam logic [2:0] MODE_FV  = 3'd4;
    localparam logic [2:0] MODE_CV  = 3'd5;
    localparam logic [2:0] MODE_VC  = 3'd6;
    localparam logic [2:0] MODE_BAD = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_ERR   = 2'd2;

    localparam logic [2:0] REG_DIMS   = 3'd0;
    localparam logic [2:0] REG_CELLS0 = 3'd1;
    localparam logic [2:0] REG_CELLS3 = 3'd4;

    // size kinds
    localparam logic [1:0] KIND_CELL  = 2'd0;
    localparam logic [1:0] KIND_VERT  = 2'd1;
    localparam logic [1:0] KIND_FACET = 2'd2;

    typedef struct packed {
        logic [2:0]                          dims;
        logic [NUM_DIMS-1:0][CELL_BITS-1:0] cells;
    } t_cfg;

    typedef struct packed {
        logic                               err;
        logic [2:0]                         mode;
        logic [2:0]                         nd;
        logic [1:0]                         fd;
        logic [NUM_DIMS-1:0][CRD_BITS-1:0] crd;
        logic [NUM_DIMS-1:0][IDX_BITS-1:0] ofs;
    } t_job;

    // extent along dimension k for a numbering kind (facet widened along dir)
    function automatic logic [CRD_BITS-1:0] dim_size(t_cfg cfg, logic [1:0] kind,
                                                     logic [1:0] dir, logic [1:0] k);
        logic [CRD_BITS-1:0] base;
        base = {1'b0, cfg.cells[k]};
        unique case (kind)
            KIND_VERT:  dim_size = base + CRD_BITS'(1);
            KIND_FACET: dim_size = base + CRD_BITS'(k == dir);
            default:    dim_size = base;
        endcase
    endfunction

endpackage

// ===== hdl/sgni_front.sv =====
module sgni_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [2:0]                   i_mode,
    input  logic [sgni_pkg::IDX_BITS-1:0] i_element_index,
    input  sgni_pkg::t_cfg               i_cfg,
    input  logic                         i_full,
    output logic                         o_busy,
    output logic                         o_push,
    output sgni_pkg::t_job               o_job
);
    import sgni_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_PROD = 3'd1;
    localparam logic [2:0] F_FIND = 3'd2;
    localparam logic [2:0] F_DIV  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;
    localparam int DIV_CYC = IDX_BITS / DIV_STEPS;
    localparam logic [3:0] DIV_LAST = 4'(DIV_CYC - 1);

    logic [2:0]                        r_state;
    logic [2:0]                        r_mode;
    logic [2:0]                        r_nd;
    logic                              r_err;
    logic [IDX_BITS-1:0]               r_e;
    logic [5:0][IDX_BITS-1:0]          r_prod;
    logic [IDX_BITS-1:0]               r_acc;
    logic [2:0]                        r_s;
    logic [1:0]                        r_k;
    logic [1:0]                        r_dir;
    logic [1:0]                        r_fd;
    logic                              r_found;
    logic [IDX_BITS-1:0]               r_rem;
    logic [IDX_BITS-1:0]               r_run;
    logic [NUM_DIMS-1:0][IDX_BITS-1:0] r_ofs;
    logic [IDX_BITS-1:0]               r_lin;
    logic [CRD_BITS:0]                 r_dr;
    logic [3:0]                        r_bit;
    logic [NUM_DIMS-1:0][CRD_BITS-1:0] r_crd;

    logic                    w_geo_ok;
    logic [2:0]              w_mode;
    logic [1:0]              w_ndm1;
    logic [1:0]              w_kind;
    logic [1:0]              w_pkind;
    logic [CRD_BITS-1:0]     w_psize;
    logic [IDX_BITS+CRD_BITS-1:0] w_pmul;
    logic [IDX_BITS-1:0]     w_fp;
    logic                    w_facet;
    logic                    w_hit;
    logic                    w_rerr;
    logic [CRD_BITS-1:0]     w_dsz;
    logic [CRD_BITS:0]       w_tr;
    logic [IDX_BITS-1:0]     w_tq;

    always_comb begin
        w_geo_ok = (i_cfg.dims >= 3'd1) && (i_cfg.dims <= 3'(MAX_DIMS));
        for (int d = 0; d < NUM_DIMS; d++) begin
            if (3'(d) < i_cfg.dims && i_cfg.cells[d] == '0) w_geo_ok = 1'b0;
        end
        w_mode = (w_geo_ok && i_cfg.dims == 3'd1 && i_mode == MODE_FV) ? MODE_VV : i_mode;
    end

    assign w_ndm1 = 2'(r_nd - 3'd1);

    always_comb begin
        case (r_mode) inside
            MODE_CC, MODE_CF, MODE_CV: w_kind = KIND_CELL;
            MODE_VV, MODE_VC:          w_kind = KIND_VERT;
            default:                   w_kind = KIND_FACET;
        endcase
    end
    assign w_facet = (w_kind == KIND_FACET);

    // product slots: 0 cells, 1 vertices, 2.. facets per direction
    assign w_pkind = (r_s == 3'd0) ? KIND_CELL : (r_s == 3'd1) ? KIND_VERT : KIND_FACET;
    assign w_psize = dim_size(i_cfg, w_pkind, 2'(r_s - 3'd2), r_k);
    assign w_pmul  = r_acc * w_psize;

    assign w_fp  = r_prod[3'(r_dir) + 3'd2];
    assign w_hit = w_facet && !r_found && (r_rem < w_fp);

    always_comb begin
        unique case (w_kind)
            KIND_CELL: w_rerr = (r_e >= r_prod[0]);
            KIND_VERT: w_rerr = (r_e >= r_prod[1]);
            default:   w_rerr = !(r_found || w_hit);
        endcase
    end

    // radix-16 restoring divide step
    assign w_dsz = dim_size(i_cfg, w_kind, r_fd, r_k);
    always_comb begin
        w_tr = r_dr;
        w_tq = r_lin;
        for (int i = 0; i < DIV_STEPS; i++) begin
            w_tr = {w_tr[CRD_BITS-1:0], w_tq[IDX_BITS-1]};
            w_tq = {w_tq[IDX_BITS-2:0], 1'b0};
            if (w_tr >= {1'b0, w_dsz}) begin
                w_tr    = w_tr - {1'b0, w_dsz};
                w_tq[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_start) begin
                        r_mode  <= w_mode;
                        r_e     <= i_element_index;
                        r_nd    <= i_cfg.dims;
                        r_err   <= !w_geo_ok || (i_mode == MODE_BAD);
                        r_crd   <= '0;
                        r_acc   <= IDX_BITS'(1);
                        r_s     <= 3'd0;
                        r_k     <= 2'd0;
                        r_dir   <= 2'd0;
                        r_fd    <= 2'd0;
                        r_found <= 1'b0;
                        r_rem   <= i_element_index;
                        r_run   <= '0;
                        r_ofs   <= '0;
                        r_state <= (!w_geo_ok || i_mode == MODE_BAD) ? F_PUSH : F_PROD;
                    end
                end
                F_PROD: begin
                    if (r_k == w_ndm1) begin
                        r_prod[r_s] <= w_pmul[IDX_BITS-1:0];
                        r_acc       <= IDX_BITS'(1);
                        r_k         <= 2'd0;
                        if (r_s == r_nd + 3'd1) r_state <= F_FIND;
                        else r_s <= r_s + 3'd1;
                    end else begin
                        r_acc <= w_pmul[IDX_BITS-1:0];
                        r_k   <= r_k + 2'd1;
                    end
                end
                F_FIND: begin
                    r_ofs[r_dir] <= r_run;
                    r_run        <= r_run + w_fp;
                    if (w_hit) begin
                        r_found <= 1'b1;
                        r_fd    <= r_dir;
                    end else if (w_facet && !r_found) begin
                        r_rem <= r_rem - w_fp;
                    end
                    if (r_dir == w_ndm1) begin
                        r_lin <= w_facet ? r_rem : r_e;
                        r_k   <= 2'd0;
                        r_dr  <= '0;
                        r_bit <= 4'd0;
                        if (w_rerr) begin
                            r_err   <= 1'b1;
                            r_state <= F_PUSH;
                        end else begin
                            r_state <= F_DIV;
                        end
                    end else begin
                        r_dir <= r_dir + 2'd1;
                    end
                end
                F_DIV: begin
                    if (r_bit == DIV_LAST) begin
                        r_crd[r_k] <= w_tr[CRD_BITS-1:0];
                        r_lin      <= w_tq;
                        r_dr       <= '0;
                        r_bit      <= 4'd0;
                        if (r_k == w_ndm1) r_state <= F_PUSH;
                        else r_k <= r_k + 2'd1;
                    end else begin
                        r_dr  <= w_tr;
                        r_lin <= w_tq;
                        r_bit <= r_bit + 4'd1;
                    end
                end
                F_PUSH: begin
                    if (!i_full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != F_IDLE);
    assign o_push = (r_state == F_PUSH) && !i_full;

    always_comb begin
        o_job.err  = r_err;
        o_job.mode = r_mode;
        o_job.nd   = r_nd;
        o_job.fd   = r_fd;
        o_job.crd  = r_crd;
        o_job.ofs  = r_ofs;
    end

endmodule

// ===== hdl/sgni_fifo.sv =====
module sgni_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sgni_pkg::t_job i_data,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output sgni_pkg::t_job o_data
);
    import sgni_pkg::*;

    localparam int DEPTH = 4;

    t_job       r_mem [DEPTH];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (i_push) r_wr <= r_wr + 2'd1;
            if (i_pop)  r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

    assign o_full  = (r_cnt == 3'(DEPTH));
    assign o_empty = (r_cnt == 3'd0);
    assign o_data  = r_mem[r_rd];

endmodule

// ===== hdl/sgni_back.sv =====
module sgni_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  sgni_pkg::t_job                i_job,
    input  sgni_pkg::t_cfg                i_cfg,
    output logic                          o_pop,
    output logic                          o_strobe,
    output logic [sgni_pkg::IDX_BITS-1:0] o_neighbor_index,
    output logic                          o_last,
    output logic [1:0]                    o_status
);
    import sgni_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_CAND = 3'd1;
    localparam logic [2:0] B_MUL  = 3'd2;
    localparam logic [2:0] B_OFS  = 3'd3;
    localparam logic [2:0] B_FIN  = 3'd4;

    logic [2:0]                        r_state;
    t_job                              r_job;
    logic [4:0]                        r_j;
    logic [NUM_DIMS-1:0][CRD_BITS-1:0] r_t;
    logic [NUM_DIMS-1:0][CRD_BITS-1:0] r_sz;
    logic [IDX_BITS-1:0]               r_ofs;
    logic [IDX_BITS-1:0]               r_acc;
    logic [1:0]                        r_k;
    logic [IDX_BITS-1:0]               r_pend;
    logic                              r_pv;
    logic                              r_strobe;
    logic [IDX_BITS-1:0]               r_nidx;
    logic                              r_last;
    logic [1:0]                        r_status;

    logic                              w_valid;
    logic [NUM_DIMS-1:0][CRD_BITS-1:0] w_t;
    logic [NUM_DIMS-1:0][CRD_BITS-1:0] w_sz;
    logic [IDX_BITS-1:0]               w_ofs;
    logic [4:0]                        w_count;
    logic [1:0]                        w_kind;
    logic [1:0]                        w_dd;
    logic [3:0]                        w_jb;
    logic [1:0]                        w_fd;
    logic [IDX_BITS+CRD_BITS-1:0]      w_mac;

    assign w_jb = r_j[3:0];
    assign w_dd = r_j[2:1];
    assign w_fd = r_job.fd;

    always_comb begin
        case (r_job.mode) inside
            MODE_CC, MODE_VV, MODE_CF: w_count = 5'(r_job.nd) << 1;
            MODE_FC:                   w_count = 5'd2;
            default:                   w_count = 5'd1 << r_job.nd;
        endcase
        case (r_job.mode) inside
            MODE_VV, MODE_FV, MODE_CV: w_kind = KIND_VERT;
            MODE_CF:                   w_kind = KIND_FACET;
            default:                   w_kind = KIND_CELL;
        endcase
    end

    // candidate target coordinates for step r_j
    always_comb begin
        w_valid = 1'b1;
        w_t     = r_job.crd;
        w_ofs   = '0;
        for (int k = 0; k < NUM_DIMS; k++) begin
            w_sz[k] = dim_size(i_cfg, w_kind, w_dd, 2'(k));
        end
        case (r_job.mode) inside
            MODE_CC, MODE_VV: begin
                if (w_jb[0]) begin
                    w_valid     = ({1'b0, r_job.crd[w_dd]} + 12'd1) < {1'b0, w_sz[w_dd]};
                    w_t[w_dd]   = r_job.crd[w_dd] + CRD_BITS'(1);
                end else begin
                    w_valid     = (r_job.crd[w_dd] != '0);
                    w_t[w_dd]   = r_job.crd[w_dd] - CRD_BITS'(1);
                end
            end
            MODE_FC: begin
                if (w_jb[0]) begin
                    w_valid   = (r_job.crd[w_fd] != '0);
                    w_t[w_fd] = r_job.crd[w_fd] - CRD_BITS'(1);
                end else begin
                    w_valid   = r_job.crd[w_fd] < {1'b0, i_cfg.cells[w_fd]};
                end
            end
            MODE_CF: begin
                w_t[w_dd] = r_job.crd[w_dd] + CRD_BITS'(w_jb[0]);
                w_ofs     = r_job.ofs[w_dd];
            end
            MODE_FV, MODE_CV: begin
                if (r_job.mode == MODE_FV && w_jb[w_fd]) w_valid = 1'b0;
                for (int k = 0; k < NUM_DIMS; k++) begin
                    w_t[k] = r_job.crd[k] + CRD_BITS'(w_jb[k]);
                end
            end
            MODE_VC: begin
                for (int k = 0; k < NUM_DIMS; k++) begin
                    w_t[k] = r_job.crd[k] - CRD_BITS'(w_jb[k]);
                    if (3'(k) < r_job.nd &&
                        (r_job.crd[k] < CRD_BITS'(w_jb[k]) || w_t[k] >= w_sz[k]))
                        w_valid = 1'b0;
                end
            end
            default: w_valid = 1'b0;
        endcase
    end

    // Horner step, highest dimension first
    assign w_mac = r_acc * r_sz[r_k] + (IDX_BITS + CRD_BITS)'(r_t[r_k]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_strobe <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_j     <= 5'd0;
                        r_pv    <= 1'b0;
                        r_state <= i_job.err ? B_FIN : B_CAND;
                    end
                end
                B_CAND: begin
                    if (r_j == w_count) begin
                        r_state <= B_FIN;
                    end else if (w_valid) begin
                        r_t     <= w_t;
                        r_sz    <= w_sz;
                        r_ofs   <= w_ofs;
                        r_acc   <= '0;
                        r_k     <= 2'(r_job.nd - 3'd1);
                        r_state <= B_MUL;
                    end else begin
                        r_j <= r_j + 5'd1;
                    end
                end
                B_MUL: begin
                    r_acc <= w_mac[IDX_BITS-1:0];
                    if (r_k == 2'd0) r_state <= B_OFS;
                    else r_k <= r_k - 2'd1;
                end
                B_OFS: begin
                    // hold one result back so the final one can carry last
                    if (r_pv) begin
                        r_strobe <= 1'b1;
                        r_nidx   <= r_pend;
                        r_last   <= 1'b0;
                        r_status <= ST_OK;
                    end
                    r_pend  <= r_acc + r_ofs;
                    r_pv    <= 1'b1;
                    r_j     <= r_j + 5'd1;
                    r_state <= B_CAND;
                end
                B_FIN: begin
                    r_strobe <= 1'b1;
                    r_last   <= 1'b1;
                    if (r_job.err) begin
                        r_nidx   <= '0;
                        r_status <= ST_ERR;
                    end else if (r_pv) begin
                        r_nidx   <= r_pend;
                        r_status <= ST_OK;
                    end else begin
                        r_nidx   <= '0;
                        r_status <= ST_EMPTY;
                    end
                    r_pv    <= 1'b0;
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_pop            = (r_state == B_IDLE) && !i_empty;
    assign o_strobe         = r_strobe;
    assign o_neighbor_index = r_nidx;
    assign o_last           = r_last;
    assign o_status         = r_status;

endmodule

// ===== hdl/structured_grid_neighbor_indices_unit.sv =====
// Structured grid neighbor indices.
// Request channel: i_mode and i_element_index are taken at a clock edge with
// i_start high and o_busy low. Results leave on o_neighbor_index, o_last and
// o_status, each valid for the single cycle that o_strobe is high; the
// receiver cannot stall, so no result waits on it.
// Configuration: i_cfg_valid with i_cfg_index / i_cfg_data; o_cfg_ready is
// always high. Index 0 is the dimension count, 1..4 the cell counts.
// Write configuration only while no request is in flight.
// The front end runs the serial product steps, the range/facet steps and the
// divider (one radix-16 step a cycle per coordinate), so the serial multiply
// and divide dominate its time. The back end runs one Horner multiply a cycle
// for each emitted result and skips invalid candidates without a multiply.
// A four-entry queue between them lets the front take the next request while
// results of earlier ones are still being produced.
// Reset (synchronous, active low) empties the queue, idles both ends and sets
// three dimensions with one cell each.
module structured_grid_neighbor_indices_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [2:0]                    i_mode,
    input  logic [sgni_pkg::IDX_BITS-1:0] i_element_index,
    output logic                          o_strobe,
    output logic [sgni_pkg::IDX_BITS-1:0] o_neighbor_index,
    output logic                          o_last,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [2:0]                    i_cfg_index,
    input  logic [sgni_pkg::CELL_BITS-1:0] i_cfg_data
);
    import sgni_pkg::*;

    t_cfg r_cfg;
    t_job w_push_job;
    t_job w_pop_job;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dims <= 3'd3;
            for (int d = 0; d < NUM_DIMS; d++) r_cfg.cells[d] <= CELL_BITS'(1);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_DIMS) begin
                r_cfg.dims <= i_cfg_data[2:0];
            end else if (i_cfg_index >= REG_CELLS0 && i_cfg_index <= REG_CELLS3) begin
                r_cfg.cells[2'(i_cfg_index - REG_CELLS0)] <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    // classify, range check and decode coordinates
    sgni_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_mode          (i_mode),
        .i_element_index (i_element_index),
        .i_cfg           (r_cfg),
        .i_full          (w_full),
        .o_busy          (o_busy),
        .o_push          (w_push),
        .o_job           (w_push_job)
    );

    sgni_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_data  (w_pop_job)
    );

    // enumerate neighbors and encode linear indices
    sgni_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (w_empty),
        .i_job            (w_pop_job),
        .i_cfg            (r_cfg),
        .o_pop            (w_pop),
        .o_strobe         (o_strobe),
        .o_neighbor_index (o_neighbor_index),
        .o_last           (o_last),
        .o_status         (o_status)
    );

endmodule

// ===== hdl/sgni_checker.sv =====
module sgni_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          o_busy,
    input logic                          o_strobe,
    input logic [sgni_pkg::IDX_BITS-1:0] o_neighbor_index,
    input logic                          o_last,
    input logic [1:0]                    o_status
);
    import sgni_pkg::*;

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status != ST_OK |-> o_last)
        else $error("error or empty result without last");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status != ST_OK |-> o_neighbor_index == '0)
        else $error("nonzero index on error or empty result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_status == ST_OK || o_status == ST_EMPTY || o_status == ST_ERR))
        else $error("undefined status code");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("not busy after a request was taken");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !o_busy)
        else $error("activity right after reset");

endmodule

bind structured_grid_neighbor_indices_unit sgni_checker u_chk (.*);

// ===== bench/structured_grid_neighbor_indices_unit_test.sv =====
module structured_grid_neighbor_indices_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sgni_pkg::*;

    typedef longint unsigned u64;

    // One expected result of the grid connectivity unit.
    typedef struct {
        logic [IDX_BITS-1:0] nbr;
        logic                last;
        logic [1:0]          status;
    } nbr_t;

    // Keeps its own copy of the grid registers, works out the neighbor list
    // of every accepted request and checks the results in order.
    class neighbor_ledger;
        u64     dims;
        u64     cells[4];
        nbr_t   pending[$];
        int     mismatches;

        function new();
            dims = 3;
            foreach (cells[k]) cells[k] = 1;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [CELL_BITS-1:0] data);
            if (idx == REG_DIMS)
                dims = data & 7;
            else if (idx <= REG_CELLS3)
                cells[idx - REG_CELLS0] = data;
        endfunction

        function u64 prod(u64 s[4], int nd);
            u64 p;
            p = 1;
            for (int d = 0; d < nd; d++) p *= s[d];
            return p;
        endfunction

        function void decode(u64 lin, u64 s[4], int nd, output u64 ix[4]);
            foreach (ix[d]) ix[d] = 0;
            for (int d = 0; d < nd; d++) begin
                ix[d] = lin % s[d];
                lin   = lin / s[d];
            end
        endfunction

        function u64 encode(u64 ix[4], u64 s[4], int nd);
            u64 lin, step;
            lin  = 0;
            step = 1;
            for (int d = 0; d < nd; d++) begin
                lin  += step * ix[d];
                step *= s[d];
            end
            return lin;
        endfunction

        function void facet_size(int dir, int nd, output u64 fs[4]);
            for (int k = 0; k < 4; k++) fs[k] = cells[k] + ((k == dir) ? 1 : 0);
        endfunction

        function bit geometry_ok();
            if (dims < 1 || dims > MAX_DIMS) return 0;
            for (int d = 0; d < dims; d++)
                if (cells[d] == 0) return 0;
            return 1;
        endfunction

        // number of elements of the source kind of a mode (0 when unusable)
        function u64 source_count(logic [2:0] mode);
            u64 v[4], fs[4], sum;
            int nd;
            if (!geometry_ok()) return 0;
            nd = int'(dims);
            foreach (v[k]) v[k] = cells[k] + 1;
            case (mode)
                MODE_CC, MODE_CF, MODE_CV: return prod(cells, nd);
                MODE_VV, MODE_VC:          return prod(v, nd);
                MODE_FC, MODE_FV: begin
                    sum = 0;
                    for (int d = 0; d < nd; d++) begin
                        facet_size(d, nd, fs);
                        sum += prod(fs, nd);
                    end
                    return sum;
                end
                default: return 0;
            endcase
        endfunction

        function void push_nbr(ref nbr_t r[$], input u64 v, input logic [1:0] st);
            nbr_t n;
            if (r.size() >= 16) return;
            n.nbr    = v[IDX_BITS-1:0];
            n.last   = 0;
            n.status = st;
            r = {r, n};
        endfunction

        function void same_level(ref nbr_t r[$], input u64 lin, input u64 s[4], input int nd);
            u64 ix[4], stride;
            decode(lin, s, nd, ix);
            stride = 1;
            for (int d = 0; d < nd; d++) begin
                if (ix[d] > 0) push_nbr(r, lin - stride, ST_OK);
                if (ix[d] + 1 < s[d]) push_nbr(r, lin + stride, ST_OK);
                stride *= s[d];
            end
        endfunction

        // Accepted request: compute its neighbor list and queue it.
        function void note_request(logic [2:0] mode_in, logic [IDX_BITS-1:0] e_in);
            nbr_t r[$];
            u64   v[4], fs[4], ix[4], tmp[4], e, rest, p, offset;
            int   nd, dir, combos;
            logic [2:0] mode;
            bit   in_grid;
            mode = mode_in;
            e    = e_in;
            nd   = int'(dims);
            foreach (v[k]) v[k] = cells[k] + 1;
            if (geometry_ok() && nd == 1 && mode == MODE_FV) mode = MODE_VV;
            dir  = 0;
            rest = e;
            if (!geometry_ok() || mode == MODE_BAD || e >= source_count(mode)) begin
                push_nbr(r, 0, ST_ERR);
            end else begin
                combos = 1 << nd;
                if (mode == MODE_FC || mode == MODE_FV) begin
                    // find the facet direction and the index within it
                    for (dir = 0; dir < nd; dir++) begin
                        facet_size(dir, nd, fs);
                        p = prod(fs, nd);
                        if (rest < p) break;
                        rest -= p;
                    end
                end
                case (mode)
                    MODE_CC: same_level(r, e, cells, nd);
                    MODE_VV: same_level(r, e, v, nd);
                    MODE_FC: begin
                        decode(rest, fs, nd, ix);
                        if (ix[dir] < cells[dir]) push_nbr(r, encode(ix, cells, nd), ST_OK);
                        if (ix[dir] > 0) begin
                            ix[dir]--;
                            push_nbr(r, encode(ix, cells, nd), ST_OK);
                        end
                    end
                    MODE_CF: begin
                        offset = 0;
                        decode(e, cells, nd, ix);
                        for (int d = 0; d < nd; d++) begin
                            facet_size(d, nd, fs);
                            push_nbr(r, offset + encode(ix, fs, nd), ST_OK);
                            ix[d]++;
                            push_nbr(r, offset + encode(ix, fs, nd), ST_OK);
                            ix[d]--;
                            offset += prod(fs, nd);
                        end
                    end
                    MODE_FV: begin
                        decode(rest, fs, nd, ix);
                        for (int c = 0; c < combos; c++) begin
                            if (c[dir]) continue;
                            for (int k = 0; k < 4; k++) tmp[k] = ix[k] + c[k];
                            push_nbr(r, encode(tmp, v, nd), ST_OK);
                        end
                    end
                    MODE_CV: begin
                        decode(e, cells, nd, ix);
                        for (int c = 0; c < combos; c++) begin
                            for (int k = 0; k < 4; k++) tmp[k] = ix[k] + c[k];
                            push_nbr(r, encode(tmp, v, nd), ST_OK);
                        end
                    end
                    default: begin
                        // vertex to cells: step down where the bit is set
                        decode(e, v, nd, ix);
                        for (int c = 0; c < combos; c++) begin
                            in_grid = 1;
                            for (int k = 0; k < nd; k++) begin
                                if (ix[k] < c[k] || ix[k] - c[k] >= cells[k]) in_grid = 0;
                                else tmp[k] = ix[k] - c[k];
                            end
                            if (in_grid) push_nbr(r, encode(tmp, cells, nd), ST_OK);
                        end
                    end
                endcase
                if (r.size() == 0) push_nbr(r, 0, ST_EMPTY);
            end
            r[r.size() - 1].last = 1;
            pending = {pending, r};
        endfunction

        function void check_result(logic [IDX_BITS-1:0] nbr, logic last, logic [1:0] st);
            nbr_t x;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: nbr=%0d last=%0b status=%0d", nbr, last, st);
                return;
            end
            x = pending.pop_front();
            if (x.nbr !== nbr || x.last !== last || x.status !== st) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("result mismatch: exp nbr=%0d last=%0b status=%0d,",
                           x.nbr, x.last, x.status);
                    $display(" got nbr=%0d last=%0b status=%0d", nbr, last, st);
                end
            end
        endfunction
    endclass

    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 600000;

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_start = 0;
    logic [2:0]            i_mode = '0;
    logic [IDX_BITS-1:0]   i_element_index = '0;
    logic                  i_cfg_valid = 0;
    logic [2:0]            i_cfg_index = '0;
    logic [CELL_BITS-1:0]  i_cfg_data = '0;
    logic                  o_busy, o_strobe, o_last, o_cfg_ready;
    logic [IDX_BITS-1:0]   o_neighbor_index;
    logic [1:0]            o_status;

    neighbor_ledger ledger = new();
    int             sent = 0;
    int             cycles = 0;

    structured_grid_neighbor_indices_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_mode           (i_mode),
        .i_element_index  (i_element_index),
        .o_strobe         (o_strobe),
        .o_neighbor_index (o_neighbor_index),
        .o_last           (o_last),
        .o_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Results cannot be held off: every strobe is checked at its edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            ledger.check_result(o_neighbor_index, o_last, o_status);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Drive one request and hold it until taken. i_start stays high on return;
    // the caller lowers it when a gap or a pause follows.
    task automatic send_request(logic [2:0] mode, logic [IDX_BITS-1:0] e);
        i_start         <= 1;
        i_mode          <= mode;
        i_element_index <= e;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        ledger.note_request(mode, e);
        sent++;
    endtask

    // Random sender gaps: 24% early, 82% in the middle, none at the end.
    task automatic sender_gap();
        int pct;
        pct = (sent < 70) ? 24 : (sent < 130) ? 82 : 0;
        if ($urandom_range(99) < pct) begin
            i_start <= 0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Lower the request line, let every expected result come, then let the
    // back end settle before anything else touches the registers.
    task automatic drain();
        i_start <= 0;
        @(posedge i_clk);
        while (ledger.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all five grid registers back to back, valid held high throughout.
    task automatic load_grid(int nd, int c0, int c1, int c2, int c3);
        logic [CELL_BITS-1:0] vals[5];
        vals = '{CELL_BITS'(nd), CELL_BITS'(c0), CELL_BITS'(c1), CELL_BITS'(c2),
                 CELL_BITS'(c3)};
        for (int i = 0; i < 5; i++) begin
            i_cfg_valid <= 1;
            i_cfg_index <= (i == 0) ? REG_DIMS : REG_CELLS0 + 3'(i - 1);
            i_cfg_data  <= vals[i];
            forever begin
                @(posedge i_clk);
                if (o_cfg_ready) break;
            end
            ledger.write_reg((i == 0) ? REG_DIMS : REG_CELLS0 + 3'(i - 1), vals[i]);
        end
        i_cfg_valid <= 0;
    endtask

    function automatic logic [IDX_BITS-1:0] rand_index(logic [2:0] mode);
        u64 cnt, r;
        int pick;
        cnt  = ledger.source_count(mode);
        r    = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (cnt == 0 || pick < 8) return r[IDX_BITS-1:0];
        if (pick < 16) return IDX_BITS'(cnt + $urandom_range(3));
        if (pick < 26) return IDX_BITS'(cnt - 1 - $urandom_range(0, (cnt > 3) ? 3 : cnt - 1));
        return IDX_BITS'(r % cnt);
    endfunction

    task automatic random_phase(int n);
        logic [2:0] mode;
        for (int i = 0; i < n; i++) begin
            mode = ($urandom_range(19) == 0) ? MODE_BAD : 3'($urandom_range(6));
            send_request(mode, rand_index(mode));
            sender_gap();
        end
        drain();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Reset grid: three dimensions of one cell, so a cell has no same-level neighbors.
        send_request(MODE_CC, 0);
        send_request(MODE_VV, 0);
        send_request(MODE_VC, 7);
        send_request(MODE_CC, 1);
        drain();

        // Directed: every mode at both ends, unsupported mode, top index.
        load_grid(3, 4, 3, 2, 1);
        for (int m = MODE_CC; m <= MODE_VC; m++) begin
            send_request(3'(m), 0);
            send_request(3'(m), IDX_BITS'(ledger.source_count(3'(m)) - 1));
        end
        send_request(MODE_BAD, 5);
        send_request(MODE_FC, IDX_BITS'(ledger.source_count(MODE_FC)));
        send_request(MODE_CV, '1);
        send_request(MODE_FV, 20);
        drain();

        // One dimension: facet-vertex behaves as vertex-vertex.
        load_grid(1, 1023, 1, 1, 1);
        send_request(MODE_FV, 0);
        send_request(MODE_FV, 512);
        send_request(MODE_FV, 1023);
        random_phase(12);

        load_grid(4, 1023, 1023, 1023, 1023);
        random_phase(18);
        load_grid(2, $urandom_range(1, 20), $urandom_range(1, 20), 1, 1);
        random_phase(18);
        load_grid(4, $urandom_range(1, 6), $urandom_range(1, 6),
                  $urandom_range(1, 6), $urandom_range(1, 6));
        random_phase(24);
        // Bad geometry: every mode must report an error.
        load_grid(0, 3, 3, 3, 3);
        random_phase(4);
        load_grid(7, 3, 3, 3, 3);
        random_phase(3);
        load_grid(3, 0, 2, 2, 2);
        random_phase(3);
        load_grid(4, 1, 1, 1, 1);
        random_phase(8);
        load_grid(3, $urandom_range(1, 1023), $urandom_range(1, 9), $urandom_range(1, 9), 1);
        random_phase(24);
        load_grid(4, $urandom_range(1, 1023), $urandom_range(1, 1023),
                  $urandom_range(1, 1023), $urandom_range(1, 1023));
        random_phase(30);

        if (ledger.mismatches == 0 && ledger.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/sgni_pkg.sv
hdl/sgni_front.sv
hdl/sgni_fifo.sv
hdl/sgni_back.sv
hdl/structured_grid_neighbor_indices_unit.sv
hdl/sgni_checker.sv
bench/structured_grid_neighbor_indices_unit_test.sv
